// ----- rtl/xrr_pkg.sv -----
// ----------------------------------------------------------------------------
// xrr_pkg: shared types and constants of the ranged xorshift128 unit
// Payload structs, generator seeds and shifts, mode codes, microcode fields.
// ----------------------------------------------------------------------------
package xrr_pkg;

	// generator seeds and shift amounts
	localparam logic [31:0] SEED_X  = 32'd123456789;
	localparam logic [31:0] SEED_Y  = 32'd362436069;
	localparam logic [31:0] SEED_Z  = 32'd521288629;
	localparam logic [31:0] SEED_W  = 32'd88675123;
	localparam int          SHIFT_T = 11;
	localparam int          SHIFT_W = 19;
	localparam int          SHIFT_U = 8;

	localparam int WORD_W = 32;
	localparam int CNT_W  = $clog2(WORD_W);

	// request modes; code 3 falls back to the raw word
	localparam logic [1:0] ACT_RAW   = 2'd0;
	localparam logic [1:0] ACT_MOD   = 2'd1;
	localparam logic [1:0] ACT_RANGE = 2'd2;

	// sequencer
	localparam int STEP_W = 2;

	localparam logic [STEP_W-1:0] STEP_IDLE  = 2'd0;
	localparam logic [STEP_W-1:0] STEP_SETUP = 2'd1;
	localparam logic [STEP_W-1:0] STEP_DIV   = 2'd2;
	localparam logic [STEP_W-1:0] STEP_EMIT  = 2'd3;

	// jump conditions: true -> target, false -> next step
	localparam logic [1:0] COND_NO_REQ   = 2'd0;
	localparam logic [1:0] COND_SHORT    = 2'd1;
	localparam logic [1:0] COND_DIV_MORE = 2'd2;
	localparam logic [1:0] COND_OUT_FULL = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic [31:0]        upper;
		logic signed [31:0] lower;
	} req_t;

	typedef struct packed {
		logic [31:0] value;
		logic        zero_divisor;
	} rsp_t;

	typedef struct packed {
		logic              take_in;
		logic              setup;
		logic              div_step;
		logic              emit;
		logic [1:0]        cond;
		logic [STEP_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic short_path;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/xrr_datapath.sv -----
// ----------------------------------------------------------------------------
// xrr_datapath: generator state, restoring divider and output register
// Driven by one control word per cycle from the sequencer.
// ----------------------------------------------------------------------------
module xrr_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  xrr_pkg::ctl_t ctl,
	input  logic          req_valid,
	input  xrr_pkg::req_t req,
	input  logic          rsp_ready,
	output logic          rsp_valid,
	output xrr_pkg::rsp_t rsp,
	output xrr_pkg::sts_t sts
);

	localparam int W = xrr_pkg::WORD_W;

	logic [W-1:0] x_q, y_q, z_q, w_q;
	logic [W-1:0] t_c, w_next_c;
	logic         adv_c;

	logic [1:0]         act_q;
	logic [W-1:0]       upper_q;
	logic signed [W-1:0] lower_q;

	logic [W-1:0]              dvs_q, dvd_q, rem_q;
	logic [xrr_pkg::CNT_W-1:0] cnt_q;
	logic                      raw_q, zero_q;

	logic [W-1:0] dvs_c;
	logic         raw_c, zero_c;
	logic [W:0]   trial_c, diff_c;
	logic         emit_c;
	logic [W-1:0] value_c;

	assign adv_c    = ctl.take_in & req_valid;
	assign t_c      = x_q ^ (x_q << xrr_pkg::SHIFT_T);
	assign w_next_c = w_q ^ (w_q >> xrr_pkg::SHIFT_W) ^ t_c ^ (t_c >> xrr_pkg::SHIFT_U);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= xrr_pkg::SEED_X;
			y_q <= xrr_pkg::SEED_Y;
			z_q <= xrr_pkg::SEED_Z;
			w_q <= xrr_pkg::SEED_W;
		end else if (adv_c) begin
			x_q <= y_q;
			y_q <= z_q;
			z_q <= w_q;
			w_q <= w_next_c;
		end
	end

	// hold the request operands for the rest of the program
	always_ff @(posedge clk) begin
		if (adv_c) begin
			act_q   <= req.action;
			upper_q <= req.upper;
			lower_q <= req.lower;
		end
	end

	always_comb begin
		if (act_q == xrr_pkg::ACT_MOD) begin
			dvs_c = upper_q;
		end else begin
			dvs_c = upper_q - $unsigned(lower_q) + W'(1);
		end
		raw_c  = (act_q != xrr_pkg::ACT_MOD) && (act_q != xrr_pkg::ACT_RANGE);
		zero_c = !raw_c && (dvs_c == '0);
	end

	// restoring division, one quotient bit per cycle
	assign trial_c = {rem_q, dvd_q[W-1]};
	assign diff_c  = trial_c - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			dvs_q  <= dvs_c;
			dvd_q  <= w_q;
			rem_q  <= '0;
			cnt_q  <= '0;
			raw_q  <= raw_c;
			zero_q <= zero_c;
		end else if (ctl.div_step) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
			if (trial_c >= {1'b0, dvs_q}) begin
				rem_q <= diff_c[W-1:0];
			end else begin
				rem_q <= trial_c[W-1:0];
			end
		end
	end

	always_comb begin
		if (zero_q) begin
			value_c = '0;
		end else if (raw_q) begin
			value_c = w_q;
		end else if (act_q == xrr_pkg::ACT_RANGE) begin
			value_c = rem_q + $unsigned(lower_q);
		end else begin
			value_c = rem_q;
		end
	end

	assign sts.out_free   = !rsp_valid || rsp_ready;
	assign sts.short_path = raw_c || zero_c;
	assign sts.div_last   = (cnt_q == xrr_pkg::CNT_W'(W - 1));
	assign emit_c         = ctl.emit && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (emit_c) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_c) begin
			rsp.value        <= value_c;
			rsp.zero_divisor <= zero_q;
		end
	end

endmodule

// ----- rtl/xrr_sequencer.sv -----
// ----------------------------------------------------------------------------
// xrr_sequencer: microcode store and step counter
// Four control words; each names a jump condition and target.
// ----------------------------------------------------------------------------
module xrr_sequencer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  xrr_pkg::sts_t sts,
	output xrr_pkg::ctl_t ctl
);

	localparam int STEPS = 2 ** xrr_pkg::STEP_W;

	// take_in, setup, div_step, emit, cond, target
	localparam xrr_pkg::ctl_t PROG [STEPS] = '{
		'{1'b1, 1'b0, 1'b0, 1'b0, xrr_pkg::COND_NO_REQ,   xrr_pkg::STEP_IDLE},
		'{1'b0, 1'b1, 1'b0, 1'b0, xrr_pkg::COND_SHORT,    xrr_pkg::STEP_EMIT},
		'{1'b0, 1'b0, 1'b1, 1'b0, xrr_pkg::COND_DIV_MORE, xrr_pkg::STEP_DIV},
		'{1'b0, 1'b0, 1'b0, 1'b1, xrr_pkg::COND_OUT_FULL, xrr_pkg::STEP_EMIT}
	};

	logic [xrr_pkg::STEP_W-1:0] step_q;
	logic                       jump_c;

	assign ctl = PROG[step_q];

	always_comb begin
		case (ctl.cond)
			xrr_pkg::COND_NO_REQ:   jump_c = !req_valid;
			xrr_pkg::COND_SHORT:    jump_c = sts.short_path;
			xrr_pkg::COND_DIV_MORE: jump_c = !sts.div_last;
			xrr_pkg::COND_OUT_FULL: jump_c = !sts.out_free;
			default:                jump_c = 1'b0;
		endcase
	end

	// fall through wraps from the emit step back to idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= xrr_pkg::STEP_IDLE;
		end else if (jump_c) begin
			step_q <= ctl.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

endmodule

// ----- rtl/xorshift128_ranged_random_unit.sv -----
// ----------------------------------------------------------------------------
// xorshift128_ranged_random_unit: ranged xorshift128 random number source
// Each request word advances the generator and returns raw, modulo or range.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | xrr_pkg::req_t (action, upper, lower)
//   rsp     | out       | rsp_valid / rsp_ready | xrr_pkg::rsp_t (value, zero_divisor)
//
// One request at a time: modulo and range modes pass accept, setup, the divider
// steps and emit; raw words and zero divisors skip the divider steps. The
// restoring divider produces one quotient bit per cycle.
// Reset loads the seeds; the unit is ready as soon as reset is released.
// A stalled response holds the emit step; a new request is still taken while
// the previous response waits in the output register.
// ----------------------------------------------------------------------------
module xorshift128_ranged_random_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  xrr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output xrr_pkg::rsp_t rsp
);

	xrr_pkg::ctl_t ctl;
	xrr_pkg::sts_t sts;

	assign req_ready = ctl.take_in;

	xrr_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.ctl       (ctl)
	);

	xrr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.req_valid (req_valid),
		.req       (req),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.sts       (sts)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while another is in flight");

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(ctl.emit))
		else $error("response raised outside the emit step");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.zero_divisor) |-> (rsp.value == '0))
		else $error("zero divisor flagged with nonzero value");

endmodule
